// ===== hw/rtl/crl_pkg.sv =====
// shared types and codes for the cursor ring list unit
package crl_pkg;

   // fixed field widths of the item ports
   localparam int unsigned COORD_BITS = 16;
   localparam int unsigned COUNT_BITS = 9;
   localparam int unsigned CMD_BITS   = 3;

   // command codes (codes above read behave as read)
   localparam logic [CMD_BITS-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_BITS-1:0] CMD_DELETE = 3'd1;
   localparam logic [CMD_BITS-1:0] CMD_NEXT   = 3'd2;
   localparam logic [CMD_BITS-1:0] CMD_PREV   = 3'd3;
   localparam logic [CMD_BITS-1:0] CMD_READ   = 3'd4;

   // status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_EMPTY   = 2'd1;
   localparam logic [1:0] STAT_REFUSED = 2'd2;
   localparam logic [1:0] STAT_FULL    = 2'd3;

   // one coordinate pair as held in the point store
   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } point_type;

   // input item
   typedef struct packed {
      logic [CMD_BITS-1:0]          cmd;
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
   } req_item_type;

   // result item
   typedef struct packed {
      logic signed [COORD_BITS-1:0] current_x;
      logic signed [COORD_BITS-1:0] current_y;
      logic [COUNT_BITS-1:0]        entry_count;
      logic [1:0]                   status;
   } rsp_item_type;

   // node store port controls
   typedef struct packed {
      logic xy_we;
      logic xy_re;
      logic next_we;
      logic next_re;
      logic prev_we;
      logic prev_re;
   } node_ctl_type;

   // free slot stack controls
   typedef struct packed {
      logic pop_re;
      logic pop;
      logic push;
   } stack_ctl_type;

endpackage

// ===== hw/rtl/crl_node_store.sv =====
// point, next link and prev link memories, one port each with registered read
module crl_node_store import crl_pkg::*; #(
   parameter int unsigned CAPACITY = 256,
   localparam int unsigned SLOT_W = $clog2(CAPACITY)
) (
   input  logic              clock,
   input  node_ctl_type      ctl,
   input  logic [SLOT_W-1:0] xy_addr,
   input  point_type         xy_wdata,
   input  logic [SLOT_W-1:0] next_addr,
   input  logic [SLOT_W-1:0] next_wdata,
   input  logic [SLOT_W-1:0] prev_addr,
   input  logic [SLOT_W-1:0] prev_wdata,
   output point_type         xy_rdata,
   output logic [SLOT_W-1:0] next_rdata,
   output logic [SLOT_W-1:0] prev_rdata
);

   point_type         xy_mem   [CAPACITY];
   logic [SLOT_W-1:0] next_mem [CAPACITY];
   logic [SLOT_W-1:0] prev_mem [CAPACITY];

   point_type         xy_rdata_ff;
   logic [SLOT_W-1:0] next_rdata_ff;
   logic [SLOT_W-1:0] prev_rdata_ff;

   // point store
   always_ff @(posedge clock) begin
      if (ctl.xy_we) begin
         xy_mem[xy_addr] <= xy_wdata;
      end else if (ctl.xy_re) begin
         xy_rdata_ff <= xy_mem[xy_addr];
      end
   end

   // forward links
   always_ff @(posedge clock) begin
      if (ctl.next_we) begin
         next_mem[next_addr] <= next_wdata;
      end else if (ctl.next_re) begin
         next_rdata_ff <= next_mem[next_addr];
      end
   end

   // backward links
   always_ff @(posedge clock) begin
      if (ctl.prev_we) begin
         prev_mem[prev_addr] <= prev_wdata;
      end else if (ctl.prev_re) begin
         prev_rdata_ff <= prev_mem[prev_addr];
      end
   end

   assign xy_rdata   = xy_rdata_ff;
   assign next_rdata = next_rdata_ff;
   assign prev_rdata = prev_rdata_ff;

endmodule

// ===== hw/rtl/crl_free_stack.sv =====
// free slot stack; entries below the low water mark read as their own index
module crl_free_stack import crl_pkg::*; #(
   parameter int unsigned CAPACITY = 256,
   localparam int unsigned SLOT_W = $clog2(CAPACITY),
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  stack_ctl_type     ctl,
   input  logic [SLOT_W-1:0] push_slot,
   output logic [SLOT_W-1:0] top_slot
);

   logic [SLOT_W-1:0] stack_mem [CAPACITY];

   logic [CNT_W-1:0]  top_ff, top_in;
   logic [CNT_W-1:0]  low_ff, low_in;
   logic [SLOT_W-1:0] rd_data_ff;
   logic [SLOT_W-1:0] rd_idx_ff;
   logic              fresh_ff;
   logic [CNT_W-1:0]  rd_ptr;
   logic [SLOT_W-1:0] rd_addr;
   logic [SLOT_W-1:0] push_addr;

   assign rd_ptr    = top_ff - 1'b1;
   assign rd_addr   = rd_ptr[SLOT_W-1:0];
   assign push_addr = top_ff[SLOT_W-1:0];

   // stack pointer and lowest depth ever reached
   always_comb begin
      top_in = top_ff;
      low_in = low_ff;
      if (ctl.pop) begin
         top_in = rd_ptr;
         if (rd_ptr < low_ff) begin
            low_in = rd_ptr;
         end
      end else if (ctl.push) begin
         top_in = top_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= CNT_W'(CAPACITY);
         low_ff <= CNT_W'(CAPACITY);
      end else begin
         top_ff <= top_in;
         low_ff <= low_in;
      end
   end

   // stack memory
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         stack_mem[push_addr] <= push_slot;
      end else if (ctl.pop_re) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   // note whether the top entry was never written since reset
   always_ff @(posedge clock) begin
      if (ctl.pop_re) begin
         rd_idx_ff <= rd_addr;
         fresh_ff  <= (rd_ptr < low_ff);
      end
   end

   assign top_slot = fresh_ff ? rd_idx_ff : rd_data_ff;

endmodule

// ===== hw/rtl/cursor_ring_list_unit.sv =====
// cursor ring list unit: circular doubly linked point list with a cursor
//
//   channel   ports                    direction   handshake
//   request   start, busy, req_item    in          taken when start and not busy
//   response  rsp_valid, rsp_item      out         one cycle strobe, no back pressure
//
// read, full insert, insert into an empty list, refused delete and empty
// commands finish in S_LINK; insert into a non-empty list goes on to S_FIX,
// set by the single port on each link memory, and delete, next and previous
// go on to S_OUT for the registered read of the new current point.
// the result register shows the item in the cycle after the final step.
// busy is high from the accept edge until the final step is done.
// reset is synchronous and leaves an empty list; no clearing pass is needed.
module cursor_ring_list_unit import crl_pkg::*; #(
   parameter int unsigned CAPACITY = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   localparam int unsigned SLOT_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_LINK = 4'b0010,
      S_FIX  = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   req_item_type      req_ff, req_in;
   logic [SLOT_W-1:0] cursor_ff, cursor_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SLOT_W-1:0] link_ff, link_in;
   point_type         cur_ff, cur_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_ff, rsp_in;

   node_ctl_type      node_ctl;
   logic [SLOT_W-1:0] xy_addr, next_addr, prev_addr;
   logic [SLOT_W-1:0] next_wdata, prev_wdata;
   point_type         xy_wdata, xy_rdata;
   logic [SLOT_W-1:0] next_rdata, prev_rdata;
   stack_ctl_type     stack_ctl;
   logic [SLOT_W-1:0] push_slot, free_slot;
   point_type         req_point;
   logic              accept;
   logic              list_full;

   function automatic rsp_item_type make_rsp(point_type pt, logic [CNT_W-1:0] cnt,
                                             logic [1:0] st);
      rsp_item_type r;
      r.current_x   = pt.x;
      r.current_y   = pt.y;
      r.entry_count = COUNT_BITS'(cnt);
      r.status      = st;
      return r;
   endfunction

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign req_point = '{x: req_ff.point_x, y: req_ff.point_y};
   assign list_full = (count_ff == CNT_W'(CAPACITY));

   // command sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cursor_in    = cursor_ff;
      count_in     = count_ff;
      slot_in      = slot_ff;
      link_in      = link_ff;
      cur_in       = cur_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      node_ctl     = '0;
      xy_addr      = cursor_ff;
      xy_wdata     = req_point;
      next_addr    = cursor_ff;
      next_wdata   = cursor_ff;
      prev_addr    = cursor_ff;
      prev_wdata   = cursor_ff;
      stack_ctl    = '0;
      push_slot    = cursor_ff;
      case (state_ff)
         S_IDLE: begin
            // fetch both links of the cursor and the free stack top
            if (accept) begin
               req_in           = req_item;
               node_ctl.next_re = 1'b1;
               node_ctl.prev_re = 1'b1;
               stack_ctl.pop_re = 1'b1;
               state_in         = S_LINK;
            end
         end
         S_LINK: begin
            if (req_ff.cmd == CMD_INSERT) begin
               if (list_full) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = make_rsp(cur_ff, count_ff, STAT_FULL);
                  state_in     = S_IDLE;
               end else begin
                  // claim a slot and store the point
                  node_ctl.xy_we = 1'b1;
                  xy_addr        = free_slot;
                  stack_ctl.pop  = 1'b1;
                  slot_in        = free_slot;
                  if (count_ff == '0) begin
                     // lone entry links to itself
                     node_ctl.next_we = 1'b1;
                     next_addr        = free_slot;
                     next_wdata       = free_slot;
                     node_ctl.prev_we = 1'b1;
                     prev_addr        = free_slot;
                     prev_wdata       = free_slot;
                     cursor_in        = free_slot;
                     count_in         = count_ff + 1'b1;
                     cur_in           = req_point;
                     rsp_valid_in     = 1'b1;
                     rsp_in           = make_rsp(req_point, count_ff + 1'b1, STAT_OK);
                     state_in         = S_IDLE;
                  end else begin
                     // splice in: cursor -> new, old next <- new
                     node_ctl.next_we = 1'b1;
                     next_addr        = cursor_ff;
                     next_wdata       = free_slot;
                     node_ctl.prev_we = 1'b1;
                     prev_addr        = next_rdata;
                     prev_wdata       = free_slot;
                     link_in          = next_rdata;
                     state_in         = S_FIX;
                  end
               end
            end else if (count_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp('0, count_ff, STAT_EMPTY);
               state_in     = S_IDLE;
            end else if (req_ff.cmd == CMD_DELETE) begin
               if (count_ff == CNT_W'(1)) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = make_rsp(cur_ff, count_ff, STAT_REFUSED);
                  state_in     = S_IDLE;
               end else begin
                  // unlink the cursor entry and free its slot
                  node_ctl.next_we = 1'b1;
                  next_addr        = prev_rdata;
                  next_wdata       = next_rdata;
                  node_ctl.prev_we = 1'b1;
                  prev_addr        = next_rdata;
                  prev_wdata       = prev_rdata;
                  stack_ctl.push   = 1'b1;
                  push_slot        = cursor_ff;
                  cursor_in        = prev_rdata;
                  count_in         = count_ff - 1'b1;
                  node_ctl.xy_re   = 1'b1;
                  xy_addr          = prev_rdata;
                  state_in         = S_OUT;
               end
            end else if (req_ff.cmd == CMD_NEXT) begin
               cursor_in      = next_rdata;
               node_ctl.xy_re = 1'b1;
               xy_addr        = next_rdata;
               state_in       = S_OUT;
            end else if (req_ff.cmd == CMD_PREV) begin
               cursor_in      = prev_rdata;
               node_ctl.xy_re = 1'b1;
               xy_addr        = prev_rdata;
               state_in       = S_OUT;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in       = make_rsp(cur_ff, count_ff, STAT_OK);
               state_in     = S_IDLE;
            end
         end
         S_FIX: begin
            // links of the new entry itself
            node_ctl.next_we = 1'b1;
            next_addr        = slot_ff;
            next_wdata       = link_ff;
            node_ctl.prev_we = 1'b1;
            prev_addr        = slot_ff;
            prev_wdata       = cursor_ff;
            cursor_in        = slot_ff;
            count_in         = count_ff + 1'b1;
            cur_in           = req_point;
            rsp_valid_in     = 1'b1;
            rsp_in           = make_rsp(req_point, count_ff + 1'b1, STAT_OK);
            state_in         = S_IDLE;
         end
         S_OUT: begin
            cur_in       = xy_rdata;
            rsp_valid_in = 1'b1;
            rsp_in       = make_rsp(xy_rdata, count_ff, STAT_OK);
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cursor_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      slot_ff <= slot_in;
      link_ff <= link_in;
      cur_ff  <= cur_in;
      rsp_ff  <= rsp_in;
   end

   crl_node_store #(
      .CAPACITY (CAPACITY)
   ) u_node_store (
      .clock      (clock),
      .ctl        (node_ctl),
      .xy_addr    (xy_addr),
      .xy_wdata   (xy_wdata),
      .next_addr  (next_addr),
      .next_wdata (next_wdata),
      .prev_addr  (prev_addr),
      .prev_wdata (prev_wdata),
      .xy_rdata   (xy_rdata),
      .next_rdata (next_rdata),
      .prev_rdata (prev_rdata)
   );

   crl_free_stack #(
      .CAPACITY (CAPACITY)
   ) u_free_stack (
      .clock     (clock),
      .reset     (reset),
      .ctl       (stack_ctl),
      .push_slot (push_slot),
      .top_slot  (free_slot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // checks
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_accept_fetch: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_LINK))
      else $error("accepted item did not start link fetch");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a command in work");

   a_full_at_capacity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == STAT_FULL) |->
      (rsp_item.entry_count == COUNT_BITS'(CAPACITY)))
      else $error("store full reported below capacity");

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the cursor ring list unit
`timescale 1ns / 100ps

module tb_top;
   import crl_pkg::*;

   localparam int unsigned RING_SLOTS = 256;

   // command codes past read, handled as read
   localparam logic [CMD_BITS-1:0] CMD_SPARE5 = 3'd5;
   localparam logic [CMD_BITS-1:0] CMD_SPARE6 = 3'd6;
   localparam logic [CMD_BITS-1:0] CMD_SPARE7 = 3'd7;

   // one directed row: command, point, and a typed result where it is obvious
   typedef struct packed {
      logic [CMD_BITS-1:0]   cmd;
      logic [15:0]           px;
      logic [15:0]           py;
      logic                  typed;
      logic [15:0]           ex;
      logic [15:0]           ey;
      logic [COUNT_BITS-1:0] ecount;
      logic [1:0]            estat;
   } dir_row_type;

   localparam int DIR_LEN = 23;
   localparam dir_row_type DIR_ROWS [0:DIR_LEN-1] = '{
      // empty list: every command but insert reports empty
      '{CMD_READ,   16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, 9'd0, STAT_EMPTY},
      '{CMD_DELETE, 16'h7FFF, 16'h8000, 1'b1, 16'h0000, 16'h0000, 9'd0, STAT_EMPTY},
      '{CMD_NEXT,   16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, 9'd0, STAT_EMPTY},
      '{CMD_PREV,   16'hFFFF, 16'hFFFF, 1'b1, 16'h0000, 16'h0000, 9'd0, STAT_EMPTY},
      '{CMD_SPARE7, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, 9'd0, STAT_EMPTY},
      // first entry links to itself
      '{CMD_INSERT, 16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF, 9'd1, STAT_OK},
      '{CMD_DELETE, 16'h0000, 16'h0000, 1'b1, 16'h8000, 16'h7FFF, 9'd1, STAT_REFUSED},
      '{CMD_NEXT,   16'h1111, 16'h2222, 1'b1, 16'h8000, 16'h7FFF, 9'd1, STAT_OK},
      '{CMD_PREV,   16'h0000, 16'h0000, 1'b1, 16'h8000, 16'h7FFF, 9'd1, STAT_OK},
      // grow the ring, new entry becomes current
      '{CMD_INSERT, 16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000, 9'd2, STAT_OK},
      '{CMD_INSERT, 16'h0000, 16'h0000, 1'b1, 16'h0000, 16'h0000, 9'd3, STAT_OK},
      '{CMD_INSERT, 16'hFFFF, 16'h0001, 1'b1, 16'hFFFF, 16'h0001, 9'd4, STAT_OK},
      // walk around the ring and past the wrap
      '{CMD_NEXT,   16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 9'd0, STAT_OK},
      '{CMD_PREV,   16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 9'd0, STAT_OK},
      '{CMD_PREV,   16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 9'd0, STAT_OK},
      '{CMD_SPARE5, 16'h5555, 16'hAAAA, 1'b0, 16'h0000, 16'h0000, 9'd0, STAT_OK},
      '{CMD_SPARE6, 16'hAAAA, 16'h5555, 1'b0, 16'h0000, 16'h0000, 9'd0, STAT_OK},
      '{CMD_READ,   16'h1234, 16'h5678, 1'b0, 16'h0000, 16'h0000, 9'd0, STAT_OK},
      // shrink back to one entry, then past it
      '{CMD_DELETE, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 9'd0, STAT_OK},
      '{CMD_DELETE, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 9'd0, STAT_OK},
      '{CMD_DELETE, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 9'd0, STAT_OK},
      '{CMD_DELETE, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000, 9'd0, STAT_OK},
      // reuse of a freed slot
      '{CMD_INSERT, 16'h5555, 16'hAAAA, 1'b0, 16'h0000, 16'h0000, 9'd0, STAT_OK}
   };

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;

   cursor_ring_list_unit #(.CAPACITY(RING_SLOTS)) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // clock, 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the ring
   point_type   slot_point [RING_SLOTS];
   logic [7:0]  fwd_link   [RING_SLOTS];
   logic [7:0]  back_link  [RING_SLOTS];
   logic [7:0]  free_stack [RING_SLOTS];
   int unsigned free_depth;
   logic [7:0]  cur_slot;
   int unsigned held;

   rsp_item_type pending_rsp [$];
   int           err_count = 0;

   // apply one command to the shadow ring and return the item it should report
   function automatic rsp_item_type ring_step(input req_item_type item);
      rsp_item_type r;
      logic [7:0]   s;
      logic [7:0]   p;
      logic [7:0]   n;
      r = '0;
      r.status = STAT_OK;
      if (item.cmd == CMD_INSERT) begin
         if (held >= RING_SLOTS || free_depth == 0) begin
            r.status = STAT_FULL;
         end else begin
            free_depth--;
            s = free_stack[free_depth];
            slot_point[s].x = item.point_x;
            slot_point[s].y = item.point_y;
            if (held == 0) begin
               fwd_link[s]  = s;
               back_link[s] = s;
            end else begin
               n = fwd_link[cur_slot];
               fwd_link[cur_slot] = s;
               back_link[s] = cur_slot;
               fwd_link[s]  = n;
               back_link[n] = s;
            end
            cur_slot = s;
            held++;
         end
      end else if (held == 0) begin
         r.status = STAT_EMPTY;
      end else if (item.cmd == CMD_DELETE) begin
         if (held == 1) begin
            r.status = STAT_REFUSED;
         end else begin
            p = back_link[cur_slot];
            n = fwd_link[cur_slot];
            fwd_link[p]  = n;
            back_link[n] = p;
            if (free_depth < RING_SLOTS) begin
               free_stack[free_depth] = cur_slot;
               free_depth++;
            end
            cur_slot = p;
            held--;
         end
      end else if (item.cmd == CMD_NEXT) begin
         cur_slot = fwd_link[cur_slot];
      end else if (item.cmd == CMD_PREV) begin
         cur_slot = back_link[cur_slot];
      end
      if (held != 0) begin
         r.current_x = slot_point[cur_slot].x;
         r.current_y = slot_point[cur_slot].y;
      end
      r.entry_count = COUNT_BITS'(held);
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      err_count++;
   endtask

   // result checker, one item per strobe against the oldest expectation
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("result item with nothing expected");
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_item.current_x !== want.current_x)
               report_mismatch($sformatf("current_x %0d, want %0d",
                                         rsp_item.current_x, want.current_x));
            if (rsp_item.current_y !== want.current_y)
               report_mismatch($sformatf("current_y %0d, want %0d",
                                         rsp_item.current_y, want.current_y));
            if (rsp_item.entry_count !== want.entry_count)
               report_mismatch($sformatf("entry_count %0d, want %0d",
                                         rsp_item.entry_count, want.entry_count));
            if (rsp_item.status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d",
                                         rsp_item.status, want.status));
         end
      end
   end

   // present one item and hold start until the block takes it
   task automatic issue(input req_item_type item, input bit typed,
                        input rsp_item_type typed_rsp);
      rsp_item_type pred;
      start    <= 1'b1;
      req_item <= item;
      do @(posedge clock); while (busy);
      pred = ring_step(item);
      pending_rsp.push_back(typed ? typed_rsp : pred);
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // random commands with a given mix; the rest are moves, reads and spare codes
   task automatic run_mix(input int n_items, input int ins_pct, input int del_pct,
                          input bit gaps);
      req_item_type item;
      int           pick;
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(99);
         if (pick < ins_pct) item.cmd = CMD_INSERT;
         else if (pick < ins_pct + del_pct) item.cmd = CMD_DELETE;
         else item.cmd = CMD_BITS'($urandom_range(CMD_NEXT, CMD_SPARE7));
         item.point_x = 16'($urandom);
         item.point_y = 16'($urandom);
         // corner coordinates now and then
         if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
               0: item.point_x = 16'h8000;
               1: item.point_x = 16'h7FFF;
               2: item.point_x = 16'hFFFF;
               default: item.point_x = 16'h0000;
            endcase
            case ($urandom_range(3))
               0: item.point_y = 16'h8000;
               1: item.point_y = 16'h7FFF;
               2: item.point_y = 16'hFFFF;
               default: item.point_y = 16'h0000;
            endcase
         end
         issue(item, 1'b0, '0);
         if (gaps && $urandom_range(3) == 0) idle_cycles($urandom_range(1, 3));
      end
   endtask

   // main sequence
   initial begin
      req_item_type item;
      rsp_item_type typed_rsp;
      int           ins_pct;
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      for (int i = 0; i < RING_SLOTS; i++) begin
         free_stack[i] = 8'(i);
         slot_point[i] = '0;
         fwd_link[i]   = '0;
         back_link[i]  = '0;
      end
      free_depth = RING_SLOTS;
      cur_slot   = '0;
      held       = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      for (int i = 0; i < DIR_LEN; i++) begin
         item.cmd               = DIR_ROWS[i].cmd;
         item.point_x           = DIR_ROWS[i].px;
         item.point_y           = DIR_ROWS[i].py;
         typed_rsp.current_x    = DIR_ROWS[i].ex;
         typed_rsp.current_y    = DIR_ROWS[i].ey;
         typed_rsp.entry_count  = DIR_ROWS[i].ecount;
         typed_rsp.status       = DIR_ROWS[i].estat;
         issue(item, DIR_ROWS[i].typed, typed_rsp);
         if ($urandom_range(3) == 0) idle_cycles($urandom_range(1, 3));
      end
      wait_drained();

      // fill past capacity, then drain down to a single entry
      run_mix(320, 92, 3, 1'b1);
      wait_drained();
      run_mix(320, 5, 85, 1'b1);
      wait_drained();

      // mixed stretches with varying growth
      for (int seg = 0; seg < 10; seg++) begin
         ins_pct = $urandom_range(20, 75);
         run_mix(100, ins_pct, 85 - ins_pct, 1'b1);
      end

      // closing stretch back to back
      run_mix(110, 40, 35, 1'b0);

      wait_drained();
      repeat (10) @(posedge clock);
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/crl_pkg.sv
hw/rtl/crl_node_store.sv
hw/rtl/crl_free_stack.sv
hw/rtl/cursor_ring_list_unit.sv
tb/tb_top.sv
